@@ sv/lasf_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers for the local alignment score fill
package lasf_pkg;

   // query store depth, rows of the score matrix
   localparam int MAX_QUERY = 64;
   localparam int ADDR_W    = $clog2(MAX_QUERY);

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int POS_W   = 6;
   localparam int SYM_W   = 8;
   localparam int ROW_W   = 7;
   localparam int COL_W   = 16;
   localparam int SCORE_W = 8;
   localparam int GAP_W   = 8;
   localparam int QLEN_W  = 7;

   // signed width used inside the cell update
   localparam int CALC_W = 11;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_SCORE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   // similarity values
   localparam logic signed [CALC_W-1:0] MATCH_SCORE    = 11'sd2;
   localparam logic signed [CALC_W-1:0] MISMATCH_SCORE = -11'sd1;
   localparam logic signed [CALC_W-1:0] SCORE_MAX      = 11'sd255;

   // register map
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_GAP  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_QLEN = 1'b1;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [GAP_W-1:0]  GAP_RESET  = 8'd1;
   localparam logic [QLEN_W-1:0] QLEN_RESET = 7'd64;

   // command queue depth
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [POS_W-1:0] position;
      logic [SYM_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   column;
      logic [SCORE_W-1:0] score;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [GAP_W-1:0]  gap_penalty;
      logic [QLEN_W-1:0] query_length;
   } cfg_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      req_type entry;
   } qhead_type;

   // clamp the configured length into 1 .. MAX_QUERY
   function automatic logic [ROW_W-1:0] rows_in_use(input logic [QLEN_W-1:0] qlen);
      logic [ROW_W-1:0] n;
      n = qlen;
      if (qlen == '0)
         n = ROW_W'(1);
      else if (qlen > QLEN_W'(MAX_QUERY))
         n = ROW_W'(MAX_QUERY);
      return n;
   endfunction

endpackage

@@ sv/lasf_ram.sv @@
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module lasf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lasf_front.sv @@
`timescale 1ns / 1ps
// input side: accepts items, drops no-op codes, queues commands for the back end
module lasf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lasf_pkg::req_type    req_data,
   output lasf_pkg::qhead_type  head,
   input  logic                 pop
);
   import lasf_pkg::*;

   req_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   logic              keep;
   logic              push;
   logic              do_pop;

   assign req_stall = (count_ff == QCNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;

   // unused code carries no work; loads beyond the store are dropped
   always_comb begin
      unique case (req_data.operation)
         OP_LOAD:  keep = (32'(req_data.position) < MAX_QUERY);
         OP_SCORE: keep = 1'b1;
         OP_CLEAR: keep = 1'b1;
         OP_NONE:  keep = 1'b0;
      endcase
   end

   assign push   = accept && keep;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

endmodule

@@ sv/lasf_back.sv @@
`timescale 1ns / 1ps
// back end: runs loads, clears and the column fill, owns the output register
module lasf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lasf_pkg::cfg_type    cfg,
   input  lasf_pkg::qhead_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lasf_pkg::rsp_type    rsp_data
);
   import lasf_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                      state_ff, state_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [ROW_W-1:0]          n_ff, n_in;
   logic [SYM_W-1:0]          sym_ff, sym_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [MAX_QUERY-1:0]      pvalid_ff, pvalid_in;

   logic                      b_valid_ff, b_valid_in;
   logic [ROW_W-1:0]          b_row_ff, b_row_in;
   logic                      b_last_ff, b_last_in;
   logic                      b_pval_ff, b_pval_in;

   logic [SCORE_W-1:0]        diag_ff, diag_in;
   logic [SCORE_W-1:0]        above_ff, above_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      start;
   logic                      issue;
   logic                      b_adv;
   logic                      out_free;
   logic [ROW_W-1:0]          row_next;
   logic [SYM_W-1:0]          q_rd;
   logic [SCORE_W-1:0]        p_rd;
   logic [SCORE_W-1:0]        left;
   logic signed [CALC_W-1:0]  sim;
   logic signed [CALC_W-1:0]  c_diag, c_up, c_left, best_s;
   logic [SCORE_W-1:0]        best;

   assign start    = (state_ff == ST_IDLE) && !b_valid_ff && head.valid;
   assign pop      = start;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign b_adv    = b_valid_ff && out_free;
   assign issue    = (state_ff == ST_RUN) && (!b_valid_ff || b_adv);
   assign row_next = row_ff + 1'b1;

   lasf_ram #(.WIDTH(SYM_W), .DEPTH(MAX_QUERY)) u_query (
      .clock   (clock),
      .wr_en   (start && (head.entry.operation == OP_LOAD)),
      .wr_addr (head.entry.position[ADDR_W-1:0]),
      .wr_data (head.entry.symbol),
      .rd_en   (issue),
      .rd_addr (row_ff[ADDR_W-1:0]),
      .rd_data (q_rd)
   );

   lasf_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_QUERY)) u_prev (
      .clock   (clock),
      .wr_en   (b_adv),
      .wr_addr (b_row_ff[ADDR_W-1:0]),
      .wr_data (best),
      .rd_en   (issue),
      .rd_addr (row_ff[ADDR_W-1:0]),
      .rd_data (p_rd)
   );

   // cell update
   always_comb begin
      left   = b_pval_ff ? p_rd : '0;
      sim    = (q_rd == sym_ff) ? MATCH_SCORE : MISMATCH_SCORE;
      c_diag = $signed(CALC_W'(diag_ff)) + sim;
      c_up   = $signed(CALC_W'(above_ff)) - $signed(CALC_W'(cfg.gap_penalty));
      c_left = $signed(CALC_W'(left)) - $signed(CALC_W'(cfg.gap_penalty));
      best_s = '0;
      if (c_diag > best_s) best_s = c_diag;
      if (c_up > best_s)   best_s = c_up;
      if (c_left > best_s) best_s = c_left;
      if (best_s > SCORE_MAX) best_s = SCORE_MAX;
      best = best_s[SCORE_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      n_in      = n_ff;
      sym_in    = sym_ff;
      col_in    = col_ff;
      pvalid_in = pvalid_ff;
      diag_in   = diag_ff;
      above_in  = above_ff;
      if (start) begin
         unique case (head.entry.operation)
            OP_SCORE: begin
               state_in = ST_RUN;
               row_in   = '0;
               n_in     = rows_in_use(cfg.query_length);
               sym_in   = head.entry.symbol;
               diag_in  = '0;
               above_in = '0;
               if (col_ff != '1) col_in = col_ff + 1'b1;
            end
            OP_CLEAR: begin
               pvalid_in = '0;
               col_in    = '0;
            end
            OP_LOAD, OP_NONE: begin
            end
         endcase
      end
      if (issue) begin
         row_in = row_next;
         if (row_next == n_ff) state_in = ST_IDLE;
      end
      if (b_adv) begin
         pvalid_in[b_row_ff[ADDR_W-1:0]] = 1'b1;
         diag_in  = left;
         above_in = best;
      end
   end

   // read data stage and output register
   always_comb begin
      b_valid_in   = issue ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
      b_row_in     = issue ? row_ff : b_row_ff;
      b_last_in    = issue ? (row_next == n_ff) : b_last_ff;
      b_pval_in    = issue ? pvalid_ff[row_ff[ADDR_W-1:0]] : b_pval_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (b_adv) begin
         rsp_valid_in  = 1'b1;
         rsp_in.row    = b_row_ff + 1'b1;
         rsp_in.column = col_ff;
         rsp_in.score  = best;
         rsp_in.last   = b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         pvalid_ff    <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         pvalid_ff    <= pvalid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      n_ff     <= n_in;
      sym_ff   <= sym_in;
      diag_ff  <= diag_in;
      above_ff <= above_in;
      b_row_ff <= b_row_in;
      b_last_ff <= b_last_in;
      b_pval_ff <= b_pval_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/local_alignment_score_fill.sv @@
`timescale 1ns / 1ps
// local alignment score fill (linear gap penalty), top level with register port.
// Query characters are loaded by position into a 64-entry store; each database
// character then produces one column of cell scores, row 1 first, the final row
// flagged by last; a clear zeroes the previous column and the column count.
// A load or a clear is carried out as it leaves the queue; a score item fills
// rows cells, where rows is query_length held to 1 .. 64, one cell per cycle
// while results are not stalled, out of the query and previous-column rams
// through the read stage and the output register.
// The two-entry command queue takes items up to its depth while a column is
// being filled and the output register holds a result. Reset needs no clearing
// pass: the previous column is tracked by per-row valid bits.
module local_alignment_score_fill (
   input  logic                           clock,
   input  logic                           reset,
   // input item channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lasf_pkg::req_type              req_data,
   // result item channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lasf_pkg::rsp_type              rsp_data,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lasf_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [lasf_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [lasf_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                           csr_pready
);
   import lasf_pkg::*;

   logic [GAP_W-1:0]     gap_ff, gap_in;
   logic [QLEN_W-1:0]    qlen_ff, qlen_in;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] reg_idx;
   cfg_type              cfg;
   qhead_type            head;
   logic                 pop;
   logic [ROW_W-1:0]     rows;

   // register port: zero wait states, word addressed
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[PADDR_W-1:2];

   always_comb begin
      gap_in  = gap_ff;
      qlen_in = qlen_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_GAP:  gap_in  = csr_pwdata[GAP_W-1:0];
            REG_QLEN: qlen_in = csr_pwdata[QLEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GAP:  csr_prdata = PDATA_W'(gap_ff);
         REG_QLEN: csr_prdata = PDATA_W'(qlen_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff  <= GAP_RESET;
         qlen_ff <= QLEN_RESET;
      end else begin
         gap_ff  <= gap_in;
         qlen_ff <= qlen_in;
      end
   end

   assign cfg.gap_penalty  = gap_ff;
   assign cfg.query_length = qlen_ff;

   // front end: take items, drop dead codes, queue commands
   lasf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   // back end: query store, previous column and the cell datapath
   lasf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // rows of the column under the current length setting
   assign rows = rows_in_use(qlen_ff);

   // a result row is always inside the matrix
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.row != '0) && (rsp_data.row <= rows))
      else $error("result row outside the matrix");

   // the final flag marks exactly the bottom row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.row == rows)))
      else $error("last flag does not match the bottom row");

   // a local score cannot exceed two points per query row
   a_score_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.score <= {rsp_data.row, 1'b0}))
      else $error("cell score above the match bound");

endmodule

@@ test/local_alignment_score_fill_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the local alignment score fill block
module local_alignment_score_fill_test;
   import lasf_pkg::*;

   // similarity of one query character against one database character
   localparam int SIM_EQUAL = 2;
   localparam int SIM_DIFF  = -1;

   localparam int PLAN_LEN      = 27;
   localparam int PHASES        = 8;
   localparam int SETTLE_CYCLES = 16;     // loads and clears may still be in flight
   localparam int TAIL_CYCLES   = 80;     // longest column plus start and drain
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int PRINT_CAP     = 30;

   // four-letter alphabet so that matches are common
   localparam logic [31:0] BASES = 32'h41_43_47_54;

   typedef enum logic {STEP_ITEM, STEP_REG} step_kind_type;

   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_COMB} flow_type;

   // one row of the directed table
   typedef struct packed {
      step_kind_type        kind;
      req_type              item;
      logic [REG_IDX_W-1:0] index;
      logic [7:0]           value;
      logic                 typed;
      logic [COL_W-1:0]     column;
      logic [SCORE_W-1:0]   score;
   } plan_step_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_type            req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_type            rsp_data;
   logic               csr_psel    = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite  = 1'b0;
   logic [PADDR_W-1:0] csr_paddr   = '0;
   logic [PDATA_W-1:0] csr_pwdata  = '0;
   logic [PDATA_W-1:0] csr_prdata;
   logic               csr_pready;

   // scoring state as the block should hold it
   logic [SYM_W-1:0]   query_mem [MAX_QUERY];
   logic [SCORE_W-1:0] prior_col [MAX_QUERY];
   bit                 loaded    [MAX_QUERY];
   logic [COL_W-1:0]   col_count;
   logic [GAP_W-1:0]   gap_reg;
   logic [QLEN_W-1:0]  qlen_reg;

   // cells still owed by the block, oldest first
   rsp_type expected_cells [$];
   int      mismatch_count = 0;

   bit hold_wanted = 1'b0;  // receiver takes one long hold-off

   local_alignment_score_fill u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch: %s got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // rows actually filled: zero counts as one, anything past the store as its size
   function automatic int active_rows();
      int n;
      n = qlen_reg;
      if (n < 1)
         n = 1;
      if (n > MAX_QUERY)
         n = MAX_QUERY;
      return n;
   endfunction

   // apply one accepted item and queue the column of cells it produces;
   // a typed row replaces the computed single cell by the one written in the table
   function automatic void fill_column(input req_type r, input bit typed, input rsp_type want);
      int      n;
      int      above;
      int      diag;
      int      left;
      int      best;
      rsp_type owed;
      case (r.operation)
         OP_LOAD: begin
            query_mem[r.position] = r.symbol;
            loaded[r.position]    = 1'b1;
         end
         OP_CLEAR: begin
            foreach (prior_col[i])
               prior_col[i] = '0;
            col_count = '0;
         end
         OP_SCORE: begin
            if (col_count != '1)
               col_count++;
            n     = active_rows();
            above = 0;
            diag  = 0;
            for (int i = 0; i < n; i++) begin
               left = prior_col[i];
               best = diag + ((query_mem[i] == r.symbol) ? SIM_EQUAL : SIM_DIFF);
               if (above - int'(gap_reg) > best)
                  best = above - int'(gap_reg);
               if (left - int'(gap_reg) > best)
                  best = left - int'(gap_reg);
               if (best < 0)
                  best = 0;
               if (best > 255)
                  best = 255;
               diag         = left;
               prior_col[i] = SCORE_W'(best);
               above        = best;
               owed.row     = ROW_W'(i + 1);
               owed.column  = col_count;
               owed.score   = SCORE_W'(best);
               owed.last    = (i == n - 1);
               if (!typed)
                  expected_cells = {expected_cells, owed};
            end
            if (typed)
               expected_cells = {expected_cells, want};
         end
         default: ;
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] pick_symbol();
      int k;
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 80)
         return BASES[8 * k +: 8];
      return SYM_W'($urandom_range(0, 255));
   endfunction

   // random item; a score is only issued once every row in use has been loaded,
   // otherwise the first missing row is loaded instead
   function automatic req_type make_item();
      req_type r;
      int      pick;
      int      n;
      int      missing;
      n       = active_rows();
      missing = -1;
      for (int i = n - 1; i >= 0; i--)
         if (!loaded[i])
            missing = i;
      r.position = POS_W'($urandom_range(0, MAX_QUERY - 1));
      r.symbol   = pick_symbol();
      pick       = $urandom_range(0, 99);
      if (pick < 14) begin
         r.operation = OP_LOAD;
         if ($urandom_range(0, 3) != 0)
            r.position = POS_W'($urandom_range(0, n - 1));
      end else if (pick < 20) begin
         r.operation = OP_CLEAR;
      end else if (pick < 24) begin
         r.operation = OP_NONE;
      end else begin
         r.operation = OP_SCORE;
      end
      if (r.operation == OP_SCORE && missing >= 0) begin
         r.operation = OP_LOAD;
         r.position  = POS_W'(missing);
      end
      return r;
   endfunction

   // offer one item and hold it until the block takes it
   task automatic send_item(input req_type r, input bit typed = 1'b0, input rsp_type want = '0);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      fill_column(r, typed, want);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // sender pauses until every owed cell has come back
   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cells.size() != 0)
         @(posedge clock);
   endtask

   // block idle: nothing owed and no load or clear left in the queue
   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   // one register transfer: setup cycle, then access cycle until pready
   task automatic csr_cycle(input logic [REG_IDX_W-1:0] index, input logic write,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= PADDR_W'({index, 2'b00});
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1)
         @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write a register, mirror it in the model and read it back
   task automatic write_register(input logic [REG_IDX_W-1:0] index,
                                 input logic [PDATA_W-1:0] value);
      logic [PDATA_W-1:0] readback;
      logic [PDATA_W-1:0] kept;
      csr_cycle(index, 1'b1, value, readback);
      if (index == REG_GAP) begin
         gap_reg = value[GAP_W-1:0];
         kept    = PDATA_W'(gap_reg);
      end else begin
         qlen_reg = value[QLEN_W-1:0];
         kept     = PDATA_W'(qlen_reg);
      end
      csr_cycle(index, 1'b0, '0, readback);
      if (readback !== kept)
         report_mismatch("register readback", readback, kept);
   endtask

   // result checker: every accepted cell against the oldest owed one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_cells.size() == 0) begin
            report_mismatch("cell with nothing owed, row", rsp_data.row, 0);
         end else begin
            want = expected_cells.pop_front();
            if (rsp_data.row !== want.row)
               report_mismatch("row", rsp_data.row, want.row);
            if (rsp_data.column !== want.column)
               report_mismatch("column", rsp_data.column, want.column);
            if (rsp_data.score !== want.score)
               report_mismatch("score", rsp_data.score, want.score);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   // receiver: stretches of free flow, light and heavy random stalls, a fixed
   // comb, and one long hold-off on request while the sender keeps offering
   initial begin
      flow_type mode;
      int       span;
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            mode = flow_type'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            for (int k = 0; k < span; k++) begin
               @(negedge clock);
               case (mode)
                  FLOW_FREE:  rsp_stall <= 1'b0;
                  FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
                  FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
                  default:    rsp_stall <= (k % 4 != 0);
               endcase
            end
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("local_alignment_score_fill regression: fail");
      $finish;
   end

   initial begin
      plan_step_type      plan [PLAN_LEN];
      logic [7:0]         phase_gap [PHASES];
      logic [7:0]         phase_qlen [PHASES];
      logic [PDATA_W-1:0] readback;
      rsp_type            want;
      req_type            r;
      int                 burst;
      int                 quota;
      int                 done;
      int                 pick;

      // model state after reset; the query store starts unknown
      foreach (prior_col[i]) begin
         prior_col[i] = '0;
         query_mem[i] = '0;
         loaded[i]    = 1'b0;
      end
      col_count = '0;
      gap_reg   = GAP_RESET;
      qlen_reg  = QLEN_RESET;

      // directed table; typed cells hold for a one-row query
      plan = '{
         '{STEP_REG,  '0,                          REG_QLEN, 8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_REG,  '0,                          REG_GAP,  8'd1,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_LOAD,  6'd0,  8'h41},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd63, 8'h41},   REG_GAP,  8'd0,   1'b1, 16'd1, 8'd2},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'h43},   REG_GAP,  8'd0,   1'b1, 16'd2, 8'd1},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'h43},   REG_GAP,  8'd0,   1'b1, 16'd3, 8'd0},
         '{STEP_ITEM, '{OP_NONE,  6'd63, 8'hff},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_CLEAR, 6'd0,  8'h00},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'h41},   REG_GAP,  8'd0,   1'b1, 16'd1, 8'd2},
         '{STEP_ITEM, '{OP_LOAD,  6'd63, 8'hff},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_LOAD,  6'd0,  8'h00},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'h00},   REG_GAP,  8'd0,   1'b1, 16'd2, 8'd2},
         '{STEP_REG,  '0,                          REG_GAP,  8'd255, 1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd21, 8'hff},   REG_GAP,  8'd0,   1'b1, 16'd3, 8'd0},
         '{STEP_REG,  '0,                          REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd42, 8'h00},   REG_GAP,  8'd0,   1'b1, 16'd4, 8'd2},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'h00},   REG_GAP,  8'd0,   1'b1, 16'd5, 8'd2},
         '{STEP_REG,  '0,                          REG_QLEN, 8'd3,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_LOAD,  6'd1,  8'h41},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_LOAD,  6'd2,  8'h00},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'h00},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd17, 8'h41},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_CLEAR, 6'd63, 8'hff},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'hff},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_REG,  '0,                          REG_GAP,  8'd2,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd5,  8'h41},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0},
         '{STEP_ITEM, '{OP_SCORE, 6'd0,  8'h00},   REG_GAP,  8'd0,   1'b0, 16'd0, 8'd0}
      };

      // random phases: mostly short queries, one past the store and one full
      phase_gap  = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd1, 8'd4};
      phase_qlen = '{8'd4, 8'd127, 8'd5, 8'd1, 8'd64, 8'd9, 8'd2, 8'd17};
      phase_gap[5] = 8'($urandom_range(0, 255));

      repeat (12)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers come out of reset at their documented values
      csr_cycle(REG_GAP, 1'b0, '0, readback);
      if (readback !== PDATA_W'(GAP_RESET))
         report_mismatch("gap penalty after reset", readback, GAP_RESET);
      csr_cycle(REG_QLEN, 1'b0, '0, readback);
      if (readback !== PDATA_W'(QLEN_RESET))
         report_mismatch("query length after reset", readback, QLEN_RESET);

      // directed part
      foreach (plan[s]) begin
         if (plan[s].kind == STEP_REG) begin
            settle();
            write_register(plan[s].index, PDATA_W'(plan[s].value));
         end else begin
            want = '{row: ROW_W'(1), column: plan[s].column, score: plan[s].score, last: 1'b1};
            send_item(plan[s].item, plan[s].typed, want);
         end
      end

      // random part: bursts of items with random gaps and the odd full drain
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_register(REG_GAP, PDATA_W'(phase_gap[p]));
         write_register(REG_QLEN, PDATA_W'(phase_qlen[p]));
         // full-height columns: hold the receiver so the block backs up
         if (p == 4)
            hold_wanted = 1'b1;
         quota = (active_rows() > 16) ? 60 : 32;
         done  = 0;
         burst = $urandom_range(1, 30);
         while (done < quota) begin
            r = make_item();
            send_item(r);
            if (r.operation != OP_NONE)
               done++;
            burst--;
            if (burst == 0) begin
               pick = $urandom_range(0, 19);
               if (pick == 0)
                  wait_results();
               else if (pick < 14)
                  idle_sender($urandom_range(1, 12));
               burst = $urandom_range(1, 30);
            end
         end
      end

      // drain, then give the block time to show any stray cell
      wait_results();
      repeat (TAIL_CYCLES)
         @(posedge clock);
      if (mismatch_count == 0)
         $display("local_alignment_score_fill regression: pass");
      else
         $display("local_alignment_score_fill regression: fail");
      $finish;
   end

endmodule

@@ local_alignment_score_fill.f @@
sv/lasf_pkg.sv
sv/lasf_ram.sv
sv/lasf_front.sv
sv/lasf_back.sv
sv/local_alignment_score_fill.sv
test/local_alignment_score_fill_test.sv
